[rtl/core/cfe_pkg.sv]
// Package for the COBS frame encoder: item, result and state types,
// encoding constants and the result constructor. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cfe_pkg;

  // One accepted input item
  typedef struct packed {
    logic [7:0] payload_byte;
    logic       frame_end;
  } cfe_item_t;

  // One frame-buffer write (result item)
  typedef struct packed {
    logic [9:0]  write_address;
    logic [7:0]  write_byte;
    logic        frame_done;
    logic        overflow;
    logic [10:0] total_length;
  } cfe_result_t;

  // Encoder state carried between items
  typedef struct packed {
    logic [7:0]  block_code;
    logic [9:0]  code_position;
    logic [10:0] write_position;
    logic        frame_aborted;
  } cfe_state_t;

  // All results caused by one item, up to four
  localparam int unsigned MaxResults = 4;

  typedef struct packed {
    logic [2:0]                        count;
    cfe_result_t [MaxResults-1:0]      slot;
  } cfe_bundle_t;

  // Encoding constants
  localparam logic [7:0]  CODE_FULL   = 8'hFF;
  localparam logic [7:0]  CODE_EMPTY  = 8'h01;
  localparam logic [7:0]  BYTE_ZERO   = 8'h00;
  localparam logic [9:0]  CAP_RESET   = 10'd1023;

  // State at the start of every frame
  localparam cfe_state_t STATE_START = '{
    block_code:     CODE_EMPTY,
    code_position:  10'd0,
    write_position: 11'd1,
    frame_aborted:  1'b0
  };

  function automatic cfe_result_t make_result(
    input logic [9:0]  addr,
    input logic [7:0]  data,
    input logic        done,
    input logic        ovf,
    input logic [10:0] len
  );
    cfe_result_t r;
    r.write_address = addr;
    r.write_byte    = data;
    r.frame_done    = done;
    r.overflow      = ovf;
    r.total_length  = len;
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/core/cfe_step.sv]
// Single-pass COBS encode step: from the held item, the state and the
// capacity, forms the bundle of writes and the next state. Uses cfe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cfe_step (
  input  cfe_pkg::cfe_item_t   item,
  input  cfe_pkg::cfe_state_t  state,
  input  logic [9:0]           cap,
  output cfe_pkg::cfe_bundle_t bundle,
  output cfe_pkg::cfe_state_t  state_next
);
  import cfe_pkg::*;

  logic [7:0]  bc;
  logic [9:0]  cp;
  logic [10:0] wp;
  logic [2:0]  k;
  logic        stop;
  logic [10:0] cap_ext;

  assign cap_ext = {1'b0, cap};

  // Walk the item through the block rules, appending writes in order
  always_comb begin
    bundle     = '0;
    state_next = state;
    bc         = state.block_code;
    cp         = state.code_position;
    wp         = state.write_position;
    k          = '0;
    stop       = 1'b0;

    if (state.frame_aborted) begin
      // dropping the rest of an overflowed frame
      if (item.frame_end) begin
        state_next = STATE_START;
      end
    end else if (cp >= cap || wp >= cap_ext) begin
      bundle.slot[0] = make_result('0, BYTE_ZERO, 1'b1, 1'b1, '0);
      k = 3'd1;
      state_next = STATE_START;
      state_next.frame_aborted = !item.frame_end;
    end else begin
      if (item.payload_byte == BYTE_ZERO) begin
        // zero closes the block
        bundle.slot[k[1:0]] = make_result(cp, bc, 1'b0, 1'b0, '0);
        k  = k + 3'd1;
        cp = wp[9:0];
        wp = wp + 11'd1;
        bc = CODE_EMPTY;
      end else begin
        bundle.slot[k[1:0]] = make_result(wp[9:0], item.payload_byte, 1'b0, 1'b0, '0);
        k  = k + 3'd1;
        wp = wp + 11'd1;
        bc = bc + 8'd1;
        if (bc == CODE_FULL) begin
          if (wp >= cap_ext) begin
            bundle.slot[k[1:0]] = make_result('0, BYTE_ZERO, 1'b1, 1'b1, '0);
            k    = k + 3'd1;
            stop = 1'b1;
            state_next = STATE_START;
            state_next.frame_aborted = !item.frame_end;
          end else begin
            // full block: back-fill 0xFF code
            bundle.slot[k[1:0]] = make_result(cp, bc, 1'b0, 1'b0, '0);
            k  = k + 3'd1;
            cp = wp[9:0];
            wp = wp + 11'd1;
            bc = CODE_EMPTY;
          end
        end
      end

      if (!stop) begin
        if (item.frame_end) begin
          // final code then delimiter
          bundle.slot[k[1:0]] = make_result(cp, bc, 1'b0, 1'b0, '0);
          k = k + 3'd1;
          bundle.slot[k[1:0]] = make_result(wp[9:0], BYTE_ZERO, 1'b1, 1'b0,
                                            wp + 11'd1);
          k = k + 3'd1;
          state_next = STATE_START;
        end else begin
          state_next.block_code     = bc;
          state_next.code_position  = cp;
          state_next.write_position = wp;
          state_next.frame_aborted  = 1'b0;
        end
      end
    end

    bundle.count = k;
  end

endmodule

`default_nettype wire

[rtl/core/cfe_serializer.sv]
// Result register for the COBS encoder: holds one item's bundle of writes
// and hands them out one per cycle while result_ready is high, on a valid/ready channel. Uses cfe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cfe_serializer (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  cfe_pkg::cfe_bundle_t bundle_in,
  output logic                 free,
  output logic                 result_valid,
  input  logic                 result_ready,
  output cfe_pkg::cfe_result_t result
);
  import cfe_pkg::*;

  cfe_bundle_t bundle;
  logic        held;
  logic [1:0]  idx;
  logic        last_slot;
  logic        taken;

  assign last_slot    = ({1'b0, idx} + 3'd1) == bundle.count;
  assign taken        = held && result_ready;
  assign free         = !held || (taken && last_slot);
  assign result_valid = held;
  assign result       = bundle.slot[idx];

  // Bundle payload, no reset needed
  always_ff @(posedge clk) begin
    if (load) begin
      bundle <= bundle_in;
    end
  end

  // Slot pointer and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
      idx  <= '0;
    end else if (load) begin
      held <= 1'b1;
      idx  <= '0;
    end else if (taken) begin
      if (last_slot) begin
        held <= 1'b0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

`ifndef SYNTHESIS
  // Pointer stays inside the loaded bundle
  a_idx_in_bundle: assert property (@(posedge clk) disable iff (rst)
    held |-> ({1'b0, idx} < bundle.count))
    else $error("slot pointer beyond bundle");

  // An overflow result carries no write
  a_ovf_shape: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.overflow |->
      result.frame_done && result.write_address == '0 && result.total_length == '0)
    else $error("malformed overflow result");

  // Length only on the closing write
  a_len_on_done: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.frame_done |-> result.total_length == '0)
    else $error("frame length on non-final result");
`endif

endmodule

`default_nettype wire

[rtl/core/cobs_frame_encoder.sv]
// Top level of the COBS frame encoder: input register, encoder state,
// capacity register, encode step and result serialiser. Uses cfe_pkg.
`timescale 1ns / 1ps
`default_nettype none

// COBS frame encoder. Each payload item (byte plus end-of-frame mark) is
// turned into frame-buffer writes (address, byte); code bytes are written
// back to their remembered positions once a block closes, and the last
// item of a frame adds the final code and a zero delimiter carrying the
// frame length. Exceeding the capacity (the smaller of frame_capacity and
// MAX_FRAME-1) gives one overflow result and the rest of the frame is
// dropped. The result register delivers one write per cycle while result_ready
// is high; an item gives as many writes as its bytes need: one for an
// ordinary byte, up to four at block and frame ends, none for bytes of a
// dropped frame. The next item is encoded in the cycle its predecessor's
// last write leaves; sustained rate is one item per cycle for plain data while result_ready stays high.
module cobs_frame_encoder #(
  parameter int unsigned MAX_FRAME = 1024
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write_en,
  input  logic [9:0]           cfg_write_data,
  input  logic                 item_valid,
  output logic                 item_ready,
  input  cfe_pkg::cfe_item_t   item,
  output logic                 result_valid,
  input  logic                 result_ready,
  output cfe_pkg::cfe_result_t result
);
  import cfe_pkg::*;

  localparam logic [9:0] CapLimit =
    (MAX_FRAME - 1 > 1023) ? 10'd1023 : 10'(MAX_FRAME - 1);

  logic [9:0]  frame_capacity;
  logic [9:0]  cap;
  cfe_item_t   item_hold;
  logic        hold_valid;
  cfe_state_t  state;
  cfe_state_t  state_next;
  cfe_bundle_t bundle;
  logic        buf_free;
  logic        consume;

  assign cap        = (frame_capacity > CapLimit) ? CapLimit : frame_capacity;
  assign consume    = hold_valid && buf_free;
  assign item_ready = !hold_valid || consume;

  // Capacity register
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_capacity <= CAP_RESET;
    end else if (cfg_write_en) begin
      frame_capacity <= cfg_write_data;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      item_hold <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (item_valid && item_ready) begin
      hold_valid <= 1'b1;
    end else if (consume) begin
      hold_valid <= 1'b0;
    end
  end

  // Encoder state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= STATE_START;
    end else if (consume) begin
      state <= state_next;
    end
  end

  cfe_step u_step (
    .item       (item_hold),
    .state      (state),
    .cap        (cap),
    .bundle     (bundle),
    .state_next (state_next)
  );

  cfe_serializer u_serializer (
    .clk          (clk),
    .rst          (rst),
    .load         (consume && (bundle.count != 3'd0)),
    .bundle_in    (bundle),
    .free         (buf_free),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

`ifndef SYNTHESIS
  // Code position always trails the write position
  a_cp_below_wp: assert property (@(posedge clk) disable iff (rst)
    {1'b0, state.code_position} < state.write_position)
    else $error("code position not below write position");

  // A dropped frame keeps the start-of-frame positions
  a_abort_at_start: assert property (@(posedge clk) disable iff (rst)
    state.frame_aborted |->
      state.code_position == '0 && state.write_position == 11'd1)
    else $error("aborted frame with live positions");

  // State moves only when an item is encoded
  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !consume |=> $stable(state))
    else $error("state changed without an item");
`endif

endmodule

`default_nettype wire

[tb/cobs_frame_encoder_checker.sv]
// Scoreboard for the COBS frame encoder: watches the capacity port and both
// channels, predicts every frame-buffer write and compares. Uses cfe_pkg.
`timescale 1ns / 1ps

module cobs_frame_encoder_checker #(
  parameter int unsigned MAX_FRAME = 1024
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write_en,
  input  logic [9:0]           cfg_write_data,
  input  logic                 item_valid,
  input  logic                 item_ready,
  input  cfe_pkg::cfe_item_t   item,
  input  logic                 result_valid,
  input  logic                 result_ready,
  input  cfe_pkg::cfe_result_t result,
  output int                   mismatches,
  output int                   pending_count
);
  import cfe_pkg::*;

  // Predicted encoder state and capacity register
  logic [7:0]  blk_code;
  logic [9:0]  code_pos;
  logic [10:0] wr_pos;
  logic        dropping;
  logic [9:0]  capacity;

  cfe_result_t expected_writes[$];
  int          fail_tally;

  function automatic void queue_write(logic [9:0] addr, logic [7:0] data, logic done,
                                      logic ovf, logic [10:0] len);
    cfe_result_t w;
    w.write_address = addr;
    w.write_byte    = data;
    w.frame_done    = done;
    w.overflow      = ovf;
    w.total_length  = len;
    expected_writes.push_back(w);
  endfunction

  function automatic void restart_frame();
    blk_code = CODE_EMPTY;
    code_pos = '0;
    wr_pos   = 11'd1;
  endfunction

  // Back-fill the open code position and open a new one
  function automatic void close_block();
    queue_write(code_pos, blk_code, 1'b0, 1'b0, '0);
    blk_code = CODE_EMPTY;
    code_pos = wr_pos[9:0];
    wr_pos   = wr_pos + 11'd1;
  endfunction

  // Overflow: one void write, rest of the frame dropped unless this was its end
  function automatic void abort_frame(logic last);
    queue_write('0, BYTE_ZERO, 1'b1, 1'b1, '0);
    restart_frame();
    dropping = !last;
  endfunction

  function automatic void encode_item(cfe_item_t it);
    int unsigned limit;
    limit = (32'(capacity) > MAX_FRAME - 1) ? MAX_FRAME - 1 : 32'(capacity);
    if (dropping) begin
      if (it.frame_end) begin
        dropping = 1'b0;
        restart_frame();
      end
      return;
    end
    if (code_pos >= limit || wr_pos >= limit) begin
      abort_frame(it.frame_end);
      return;
    end
    if (it.payload_byte == BYTE_ZERO) begin
      close_block();
    end else begin
      queue_write(wr_pos[9:0], it.payload_byte, 1'b0, 1'b0, '0);
      wr_pos   = wr_pos + 11'd1;
      blk_code = blk_code + 8'd1;
      // full block of 254 data bytes closes with the 0xFF code
      if (blk_code == CODE_FULL) begin
        if (wr_pos >= limit) begin
          abort_frame(it.frame_end);
          return;
        end
        close_block();
      end
    end
    if (it.frame_end) begin
      queue_write(code_pos, blk_code, 1'b0, 1'b0, '0);
      queue_write(wr_pos[9:0], BYTE_ZERO, 1'b1, 1'b0, wr_pos + 11'd1);
      restart_frame();
    end
  endfunction

  function automatic bit field_ok(string name, int unsigned want, int unsigned got);
    if (want == got) return 1'b1;
    $display("%0t ns: %s mismatch, expected %0d (0x%0h), got %0d (0x%0h)",
             $time, name, want, want, got, got);
    return 1'b0;
  endfunction

  // Sample on the clock edge: config, result check, then prediction
  always @(posedge clk) begin
    cfe_result_t want;
    bit          ok;
    if (rst) begin
      capacity = CAP_RESET;
      restart_frame();
      dropping = 1'b0;
      expected_writes.delete();
      fail_tally = 0;
    end else begin
      if (cfg_write_en) capacity = cfg_write_data;
      if (result_valid && result_ready) begin
        if (expected_writes.size() == 0) begin
          $display("%0t ns: unexpected write, expected none, got addr %0d byte 0x%0h",
                   $time, result.write_address, result.write_byte);
          fail_tally++;
        end else begin
          want = expected_writes.pop_front();
          ok = field_ok("write_address", 32'(want.write_address),
                        32'(result.write_address))
             & field_ok("write_byte", 32'(want.write_byte), 32'(result.write_byte))
             & field_ok("frame_done", 32'(want.frame_done), 32'(result.frame_done))
             & field_ok("overflow", 32'(want.overflow), 32'(result.overflow))
             & field_ok("total_length", 32'(want.total_length),
                        32'(result.total_length));
          if (!ok) fail_tally++;
        end
      end
      if (item_valid && item_ready) encode_item(item);
    end
    pending_count <= expected_writes.size();
    mismatches    <= fail_tally;
  end

endmodule

[tb/cobs_frame_encoder_tb.sv]
// Testbench top for the COBS frame encoder: clock, reset, stimulus and
// verdict. Depends on cfe_pkg, cobs_frame_encoder and the checker module.
`timescale 1ns / 1ps

module cobs_frame_encoder_tb;
  import cfe_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 600000;
  localparam int unsigned SETTLE_CYCLES = 10;
  localparam int unsigned PHASE_ITEMS   = 33;
  localparam int unsigned NUM_PHASES    = 8;

  logic        clk;
  logic        rst;
  logic        cfg_write_en;
  logic [9:0]  cfg_write_data;
  logic        item_valid;
  logic        item_ready;
  cfe_item_t   item;
  logic        result_valid;
  logic        result_ready;
  cfe_result_t result;

  int          mismatches;
  int          pending_writes;
  int unsigned cycle_count = 0;
  int unsigned items_sent  = 0;
  bit          send_idling = 1'b1;
  bit          recv_idling = 1'b1;

  cobs_frame_encoder i_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .item_valid     (item_valid),
    .item_ready     (item_ready),
    .item           (item),
    .result_valid   (result_valid),
    .result_ready   (result_ready),
    .result         (result)
  );

  cobs_frame_encoder_checker i_checker (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .item_valid     (item_valid),
    .item_ready     (item_ready),
    .item           (item),
    .result_valid   (result_valid),
    .result_ready   (result_ready),
    .result         (result),
    .mismatches     (mismatches),
    .pending_count  (pending_writes)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Result side: random stall before each write, or none in quiet stretches
  initial begin
    int unsigned stall;
    result_ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = recv_idling ? $urandom_range(0, 19) : 0;
      if (stall > 0) begin
        result_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_ready <= 1'b1;
      @(posedge clk);
      while (!result_valid) @(posedge clk);
    end
  end

  // Offer one item and hold it until accepted; valid stays high afterwards
  task automatic send_item(input logic [7:0] data, input logic last);
    int unsigned gap;
    gap = send_idling ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid        <= 1'b1;
    item.payload_byte <= data;
    item.frame_end    <= last;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    items_sent++;
  endtask

  // Stop sending and wait for every predicted write, then let the block settle
  task automatic drain();
    item_valid <= 1'b0;
    @(posedge clk);
    while (pending_writes != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_capacity(input logic [9:0] value);
    drain();
    cfg_write_en   <= 1'b1;
    cfg_write_data <= value;
    @(posedge clk);
    cfg_write_en   <= 1'b0;
  endtask

  // Payload biased towards zeros and the byte extremes
  function automatic logic [7:0] random_byte();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 3) return BYTE_ZERO;
    if (pick == 3) return 8'hFF;
    if (pick == 4) return 8'h01;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_frame(input int unsigned len);
    for (int unsigned i = 0; i < len; i++) send_item(random_byte(), i == len - 1);
  endtask

  // 254 non-zero bytes in one block; the last one may or may not end the frame
  task automatic send_full_block(input logic last);
    for (int unsigned i = 0; i < 254; i++)
      send_item(8'($urandom_range(1, 255)), (i == 253) ? last : 1'b0);
  endtask

  initial begin
    int unsigned phase_start;
    logic [9:0]  cap;
    logic        ends;

    rst            <= 1'b1;
    cfg_write_en   <= 1'b0;
    cfg_write_data <= '0;
    item_valid     <= 1'b0;
    item           <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset capacity, lone zero, byte extremes, consecutive zeros
    send_item(BYTE_ZERO, 1'b1);
    send_item(8'hFF, 1'b0);
    send_item(BYTE_ZERO, 1'b0);
    send_item(8'h7F, 1'b0);
    send_item(8'h01, 1'b0);
    send_item(8'h80, 1'b1);
    send_item(BYTE_ZERO, 1'b0);
    send_item(BYTE_ZERO, 1'b1);

    // Capacity lowered mid-frame: next byte overflows, the rest is dropped
    send_item(8'h11, 1'b0);
    send_item(BYTE_ZERO, 1'b0);
    send_item(8'h22, 1'b0);
    set_capacity(10'd3);
    send_item(8'h44, 1'b0);
    send_item(8'h55, 1'b1);

    // Zero capacity: overflow on the first byte, with and without frame end
    set_capacity(10'd0);
    send_item(8'hAA, 1'b1);
    send_item(8'h5A, 1'b0);
    send_item(8'hA5, 1'b0);
    send_item(8'h3C, 1'b1);

    // Small capacity: delimiter right at the limit, then overflow on the end byte
    set_capacity(10'd4);
    send_item(8'h01, 1'b0);
    send_item(8'h02, 1'b0);
    send_item(8'h03, 1'b1);
    send_item(8'h01, 1'b0);
    send_item(8'h02, 1'b0);
    send_item(8'h03, 1'b0);
    send_item(8'h04, 1'b1);

    // Random phases, each with its own capacity
    for (int unsigned phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0: cap = CAP_RESET;
        1: cap = 10'($urandom_range(1, 16));
        2: cap = '0;
        3: cap = 10'($urandom_range(17, 200));
        4: cap = CAP_RESET;
        5: cap = 10'd255;
        6: cap = 10'($urandom_range(0, 1023));
        default: cap = 10'($urandom_range(2, 8));
      endcase
      set_capacity(cap);
      send_idling = $urandom_range(0, 3) != 0;
      recv_idling = $urandom_range(0, 3) != 0;

      // exactly 254 data bytes at frame end: 0xFF code, final 0x01 code
      if (phase == 4) send_full_block(1'b1);
      // 254th byte hits capacity 255 after its data write
      if (phase == 5) begin
        ends = 1'($urandom_range(0, 1));
        send_full_block(ends);
        if (!ends) send_item(8'($urandom_range(0, 255)), 1'b1);
      end

      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) begin
        if ($urandom_range(0, 7) == 0) send_idling = !send_idling;
        if ($urandom_range(0, 7) == 0) recv_idling = !recv_idling;
        send_frame(($urandom_range(0, 9) == 0) ? $urandom_range(12, 40)
                                                : $urandom_range(1, 6));
      end

      // sometimes leave a frame open across the capacity change, but the
      // full-block phases start from a fresh frame
      if (phase != 3 && phase != 4 && $urandom_range(0, 1) == 1) begin
        for (int unsigned i = $urandom_range(1, 5); i > 0; i--)
          send_item(random_byte(), 1'b0);
      end
    end

    drain();
    if (mismatches == 0 && pending_writes == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
